[rtl/core/itt_pkg.sv]
// Package for the two-channel interval timer.
// Holds action and port codes, command field codes, the channel operation
// struct and the count period function. No dependencies.
package itt_pkg;

    localparam int unsigned CountWidth = 16;

    typedef logic [1:0] t_action;
    localparam t_action ACT_TICK  = 2'd0;
    localparam t_action ACT_WRITE = 2'd1;
    localparam t_action ACT_READ  = 2'd2;

    typedef logic [2:0] t_port;
    localparam t_port PORT_CH0 = 3'd0;
    localparam t_port PORT_CH2 = 3'd2;
    localparam t_port PORT_CMD = 3'd3;
    localparam t_port PORT_CTL = 3'd4;

    typedef logic [1:0] t_access;
    localparam t_access ACC_NONE = 2'd0;
    localparam t_access ACC_LOW  = 2'd1;
    localparam t_access ACC_HIGH = 2'd2;
    localparam t_access ACC_LOHI = 2'd3;

    typedef logic [1:0] t_select;
    localparam t_select SEL_CH0 = 2'd0;
    localparam t_select SEL_CH2 = 2'd2;

    typedef struct packed {
        logic       tick;
        logic       cmd_wr;
        logic       data_wr;
        logic       ctl_wr;
        logic [7:0] wbyte;
        logic       gate;
        logic       gate_new;
    } t_chan_op;

    function automatic logic [CountWidth:0] itt_period(input logic [CountWidth-1:0] reload);
        logic [CountWidth:0] p;
        p = (reload == '0) ? {1'b1, {CountWidth{1'b0}}} : {1'b0, reload};
        return p;
    endfunction

endpackage

[rtl/core/itt_if.sv]
// Handshake interfaces for the interval timer's item and result channels.
// Depends on nothing.
interface itt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] port_select;
    logic [7:0] write_byte;
    modport source (output valid, output action, output port_select, output write_byte,
                    input ready);
    modport sink (input valid, input action, input port_select, input write_byte,
                  output ready);
endinterface

interface itt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_pulse;
    logic       out_two;
    logic       speaker;
    modport source (output valid, output read_byte, output irq_pulse, output out_two,
                    output speaker, input ready);
    modport sink (input valid, input read_byte, input irq_pulse, input out_two,
                  input speaker, output ready);
endinterface

[rtl/core/interval_timer_two_channel_top.sv]
// Usage notes:
// Two-channel interval timer (channels 0 and 2 of a classic PC timer) with a
// system control port for the channel-2 gate and speaker enable.
// Items arrive on i_item: one input-clock tick, a port write or a port read.
// Every accepted item gives exactly one result beat on o_result, carrying the
// system control read data, the channel-0 interrupt pulse, the channel-2
// output level and the gated speaker signal.
// An item is captured in an input register; when it advances (the result
// register is empty or being taken), its state update is committed while the
// result register is loaded.
// Throughput is one item per cycle while o_result.ready stays high; the only
// feedback path is a single decrement and compare on each 17-bit counter.
// When the receiver stalls, the result register holds its beat and the input
// register still accepts one more item; after that i_item.ready drops until
// the result is taken.
// Reset clears both channels to stopped with output low, selects low-then-high
// access, clears the control bits and empties both registers.
// Top level of the interval timer. Depends on itt_pkg, itt_if and itt_channel.
module interval_timer_two_channel_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itt_in_if.sink    i_item,
    itt_out_if.source o_result
);
    import itt_pkg::*;

    logic       r_in_valid;
    t_action    r_in_action;
    t_port      r_in_port;
    logic [7:0] r_in_byte;
    logic [3:0] r_ctl, n_ctl;
    logic       r_res_valid;
    logic [7:0] r_res_read;
    logic       r_res_irq;
    logic       r_res_out2;
    logic       r_res_spk;

    logic       w_advance;
    logic       w_wr;
    logic       w_cmd_ok;
    t_chan_op   w_op0, w_op2;
    logic       w_out0, w_out0_next, w_rise0;
    logic       w_out2, w_out2_next, w_rise2;
    logic [7:0] w_read;

    assign w_advance    = r_in_valid && (!r_res_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_action <= i_item.action;
            r_in_port   <= i_item.port_select;
            r_in_byte   <= i_item.write_byte;
        end
    end

    assign w_wr     = (r_in_action == ACT_WRITE);
    assign w_cmd_ok = w_wr && (r_in_port == PORT_CMD) && (r_in_byte[5:4] != ACC_NONE);

    always_comb begin
        w_op0.tick     = (r_in_action == ACT_TICK);
        w_op0.cmd_wr   = w_cmd_ok && (r_in_byte[7:6] == SEL_CH0);
        w_op0.data_wr  = w_wr && (r_in_port == PORT_CH0);
        w_op0.ctl_wr   = 1'b0;
        w_op0.wbyte    = r_in_byte;
        w_op0.gate     = 1'b1;
        w_op0.gate_new = 1'b1;
        w_op2.tick     = (r_in_action == ACT_TICK);
        w_op2.cmd_wr   = w_cmd_ok && (r_in_byte[7:6] == SEL_CH2);
        w_op2.data_wr  = w_wr && (r_in_port == PORT_CH2);
        w_op2.ctl_wr   = w_wr && (r_in_port == PORT_CTL);
        w_op2.wbyte    = r_in_byte;
        w_op2.gate     = r_ctl[0];
        w_op2.gate_new = r_in_byte[0];
    end

    assign n_ctl  = (w_wr && r_in_port == PORT_CTL) ? r_in_byte[3:0] : r_ctl;
    assign w_read = (r_in_action == ACT_READ && r_in_port == PORT_CTL) ?
                    {2'b00, w_out2, 1'b0, r_ctl} : 8'h00;

    itt_channel u_ch0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op0),
        .i_commit   (w_advance),
        .o_out      (w_out0),
        .o_out_next (w_out0_next),
        .o_rise     (w_rise0)
    );

    itt_channel u_ch2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op2),
        .i_commit   (w_advance),
        .o_out      (w_out2),
        .o_out_next (w_out2_next),
        .o_rise     (w_rise2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_ctl <= n_ctl;
            end
            if (w_advance) begin
                r_res_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res_read <= w_read;
            r_res_irq  <= w_rise0;
            r_res_out2 <= w_out2_next;
            r_res_spk  <= w_out2_next && n_ctl[1];
        end
    end

    assign o_result.valid     = r_res_valid;
    assign o_result.read_byte = r_res_read;
    assign o_result.irq_pulse = r_res_irq;
    assign o_result.out_two   = r_res_out2;
    assign o_result.speaker   = r_res_spk;

    a_ready_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> r_in_valid && r_res_valid)
        else $error("input stalled while a register is free");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !r_res_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_speaker_needs_out2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_spk |-> r_res_out2)
        else $error("speaker high while channel 2 output low");

    a_irq_not_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res_irq |-> r_res_read == 8'h00)
        else $error("interrupt pulse on a read beat");

    a_rise_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (w_rise0 || w_rise2) |->
            (w_rise0 ? (!w_out0 && w_out0_next) : (!w_out2 && w_out2_next)))
        else $error("rise reported on an output already high");

endmodule

[rtl/core/itt_channel.sv]
// One counter channel of the interval timer: state registers and next-state logic.
// Depends on itt_pkg.
module itt_channel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  itt_pkg::t_chan_op i_op,
    input  logic            i_commit,
    output logic            o_out,
    output logic            o_out_next,
    output logic            o_rise
);
    import itt_pkg::*;

    logic [CountWidth:0]   r_cnt, n_cnt;
    logic [CountWidth-1:0] r_reload, n_reload;
    logic [2:0]            r_mode, n_mode;
    t_access               r_acc, n_acc;
    logic                  r_hbn, n_hbn;
    logic                  r_out, n_out;
    logic                  r_run, n_run;
    logic [CountWidth:0]   w_period;
    logic [CountWidth:0]   w_sq_dec;
    logic                  w_load;

    assign w_period = itt_period(r_reload);
    assign w_sq_dec = (r_cnt == '0 || r_cnt > w_period) ? '0 : r_cnt - 1'b1;

    always_comb begin
        n_cnt    = r_cnt;
        n_reload = r_reload;
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_hbn    = r_hbn;
        n_out    = r_out;
        n_run    = r_run;
        w_load   = 1'b0;
        if (i_op.tick) begin
            if (r_run && i_op.gate) begin
                if (r_mode[1]) begin
                    if (w_sq_dec == '0) begin
                        n_cnt = w_period;
                        n_out = 1'b1;
                    end else begin
                        n_cnt = w_sq_dec;
                        n_out = (w_sq_dec > (w_period >> 1));
                    end
                end else if (r_cnt <= 1) begin
                    n_cnt = '0;
                    n_out = 1'b1;
                    n_run = 1'b0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end else if (i_op.cmd_wr) begin
            n_acc  = i_op.wbyte[5:4];
            n_mode = i_op.wbyte[3:1];
            n_hbn  = 1'b0;
            n_run  = 1'b0;
            n_out  = i_op.wbyte[2];
        end else if (i_op.data_wr) begin
            case (r_acc)
                ACC_LOW: begin
                    n_reload = {8'h00, i_op.wbyte};
                    w_load   = 1'b1;
                end
                ACC_HIGH: begin
                    n_reload = {i_op.wbyte, 8'h00};
                    w_load   = 1'b1;
                end
                ACC_LOHI: begin
                    if (!r_hbn) begin
                        n_reload = {r_reload[15:8], i_op.wbyte};
                        n_hbn    = 1'b1;
                        if (!r_mode[1]) begin
                            n_run = 1'b0;
                        end
                    end else begin
                        n_reload = {i_op.wbyte, r_reload[7:0]};
                        n_hbn    = 1'b0;
                        w_load   = 1'b1;
                    end
                end
                default: begin
                    n_reload = r_reload;
                end
            endcase
            if (w_load) begin
                n_cnt = itt_period(n_reload);
                n_run = 1'b1;
                n_out = r_mode[1];
            end
        end else if (i_op.ctl_wr) begin
            if (r_mode[1]) begin
                if (!i_op.gate_new) begin
                    n_out = 1'b1;
                end else if (!i_op.gate && r_run) begin
                    n_cnt = w_period;
                    n_out = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_reload <= '0;
            r_mode   <= '0;
            r_acc    <= ACC_LOHI;
            r_hbn    <= 1'b0;
            r_out    <= 1'b0;
            r_run    <= 1'b0;
        end else if (i_commit) begin
            r_cnt    <= n_cnt;
            r_reload <= n_reload;
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_hbn    <= n_hbn;
            r_out    <= n_out;
            r_run    <= n_run;
        end
    end

    assign o_out      = r_out;
    assign o_out_next = n_out;
    assign o_rise     = i_op.tick && !r_out && n_out;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the two-channel interval timer top level.
// Depends on itt_pkg, itt_if and interval_timer_two_channel_top.
module tb;
    import itt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int RAND_ITEMS   = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    localparam t_action ACT_SPARE = 2'd3;
    localparam t_port   PORT_CH1  = 3'd1;
    localparam t_port   PORT_TOP  = 3'd7;
    localparam int      CTL_GATE  = 0;
    localparam int      CTL_SPK   = 1;

    localparam logic [7:0] CMD_CH0_SQUARE_LOHI_BCD = 8'h37;
    localparam logic [7:0] CMD_CH2_ONESHOT_LOHI    = 8'hB0;
    localparam logic [7:0] CMD_LATCH               = 8'h00;
    localparam logic [7:0] CMD_CH1                 = 8'h7E;
    localparam logic [7:0] CMD_READBACK            = 8'hFE;
    localparam logic [7:0] CMD_CH2_SQUARE_LOW      = 8'h96;
    localparam logic [7:0] CMD_CH2_RATE_HIGH       = 8'hA4;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       irq;
        logic       ch2_out;
        logic       spk;
    } t_timer_beat;

    typedef struct packed {
        t_action     act;
        t_port       port;
        logic [7:0]  wbyte;
        logic        fixed;
        t_timer_beat beat;
    } t_timer_item;

    localparam t_timer_beat IDLE_BEAT    = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam t_timer_beat CTL_ALL_BEAT = '{8'h0F, 1'b0, 1'b0, 1'b0};

    localparam int NUM_DIRECTED = 28;
    localparam t_timer_item DIRECTED [NUM_DIRECTED] = '{
        '{ACT_READ,  PORT_CTL, 8'h00, 1'b1, IDLE_BEAT},
        '{ACT_WRITE, PORT_CTL, 8'hFF, 1'b1, IDLE_BEAT},
        '{ACT_READ,  PORT_CTL, 8'h00, 1'b1, CTL_ALL_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_CH0_SQUARE_LOHI_BCD, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH0, 8'h04, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_CH2_ONESHOT_LOHI, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH2, 8'h02, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH2, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_TICK,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_READ,  PORT_CTL, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_LATCH, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_CH1, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_READBACK, 1'b0, IDLE_BEAT},
        '{ACT_SPARE, PORT_TOP, 8'hFF, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH1, 8'hAA, 1'b0, IDLE_BEAT},
        '{ACT_READ,  PORT_CH0, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_CH2_SQUARE_LOW, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH2, 8'h00, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CTL, 8'h02, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CTL, 8'h03, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CMD, CMD_CH2_RATE_HIGH, 1'b0, IDLE_BEAT},
        '{ACT_WRITE, PORT_CH2, 8'hFF, 1'b0, IDLE_BEAT}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic go      = 1'b0;

    itt_in_if  item_if ();
    itt_out_if result_if ();

    interval_timer_two_channel_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Timer state as seen from the ports; index 0 is channel 0, index 1 is channel 2.
    logic [16:0] tmr_count   [2] = '{17'd0, 17'd0};
    logic [15:0] tmr_reload  [2] = '{16'd0, 16'd0};
    logic [2:0]  tmr_mode    [2] = '{3'd0, 3'd0};
    t_access     tmr_access  [2] = '{ACC_LOHI, ACC_LOHI};
    logic        tmr_hi_next [2] = '{1'b0, 1'b0};
    logic        tmr_out     [2] = '{1'b0, 1'b0};
    logic        tmr_run     [2] = '{1'b0, 1'b0};
    logic [3:0]  ctl_bits        = 4'd0;

    t_timer_item stim_q [$];
    t_timer_beat expected_beats [$];
    t_timer_item cur_item;

    int cycle_count = 0;
    int mismatches  = 0;
    int n_accepted  = 0;
    int n_ticks     = 0;
    int n_checked   = 0;
    int n_irq       = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int rx_mode     = 0;
    int rx_left     = 0;
    logic [7:0] rx_pat = 8'hFF;

    function automatic logic [16:0] full_period(int ch);
        return (tmr_reload[ch] == 16'd0) ? 17'h10000 : {1'b0, tmr_reload[ch]};
    endfunction

    function automatic logic is_square(int ch);
        return tmr_mode[ch][1];
    endfunction

    function automatic void start_count(int ch);
        tmr_count[ch] = full_period(ch);
        tmr_run[ch]   = 1'b1;
        tmr_out[ch]   = is_square(ch);
    endfunction

    function automatic logic tick_chan(int ch);
        logic        was;
        logic [16:0] n;
        logic [16:0] c;
        was = tmr_out[ch];
        if (!tmr_run[ch] || (ch == 1 && !ctl_bits[CTL_GATE])) return 1'b0;
        if (is_square(ch)) begin
            n = full_period(ch);
            c = tmr_count[ch];
            c = (c == 17'd0 || c > n) ? 17'd0 : c - 17'd1;
            if (c == 17'd0) begin
                tmr_count[ch] = n;
                tmr_out[ch]   = 1'b1;
            end else begin
                tmr_count[ch] = c;
                tmr_out[ch]   = (c > (n >> 1));
            end
        end else if (tmr_count[ch] <= 17'd1) begin
            tmr_count[ch] = 17'd0;
            tmr_out[ch]   = 1'b1;
            tmr_run[ch]   = 1'b0;
        end else begin
            tmr_count[ch] = tmr_count[ch] - 17'd1;
        end
        return !was && tmr_out[ch];
    endfunction

    function automatic void load_byte(int ch, logic [7:0] b);
        case (tmr_access[ch])
            ACC_LOW: begin
                tmr_reload[ch] = {8'h00, b};
                start_count(ch);
            end
            ACC_HIGH: begin
                tmr_reload[ch] = {b, 8'h00};
                start_count(ch);
            end
            ACC_LOHI: begin
                if (!tmr_hi_next[ch]) begin
                    tmr_reload[ch][7:0] = b;
                    tmr_hi_next[ch] = 1'b1;
                    if (!is_square(ch)) tmr_run[ch] = 1'b0;
                end else begin
                    tmr_reload[ch][15:8] = b;
                    tmr_hi_next[ch] = 1'b0;
                    start_count(ch);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void write_command(logic [7:0] b);
        t_select sel;
        t_access acc;
        int      ch;
        sel = b[7:6];
        acc = b[5:4];
        if (acc == ACC_NONE || (sel != SEL_CH0 && sel != SEL_CH2)) return;
        ch = (sel == SEL_CH0) ? 0 : 1;
        tmr_access[ch]  = acc;
        tmr_mode[ch]    = b[3:1];
        tmr_hi_next[ch] = 1'b0;
        tmr_run[ch]     = 1'b0;
        tmr_out[ch]     = is_square(ch);
    endfunction

    function automatic void write_control(logic [7:0] b);
        logic old_gate;
        old_gate = ctl_bits[CTL_GATE];
        ctl_bits = b[3:0];
        if (is_square(1)) begin
            if (!ctl_bits[CTL_GATE]) begin
                tmr_out[1] = 1'b1;
            end else if (!old_gate && tmr_run[1]) begin
                tmr_count[1] = full_period(1);
                tmr_out[1]   = 1'b1;
            end
        end
    endfunction

    function automatic t_timer_beat timer_step(t_action act, t_port port, logic [7:0] b);
        t_timer_beat r;
        logic        ch2_rose;
        r = IDLE_BEAT;
        case (act)
            ACT_TICK: begin
                r.irq    = tick_chan(0);
                ch2_rose = tick_chan(1);
            end
            ACT_WRITE: begin
                case (port)
                    PORT_CH0: load_byte(0, b);
                    PORT_CH2: load_byte(1, b);
                    PORT_CMD: write_command(b);
                    PORT_CTL: write_control(b);
                    default: ;
                endcase
            end
            ACT_READ: begin
                if (port == PORT_CTL) r.rd_data = {2'b00, tmr_out[1], 1'b0, ctl_bits};
            end
            default: ;
        endcase
        r.ch2_out = tmr_out[1];
        r.spk     = tmr_out[1] & ctl_bits[CTL_SPK];
        return r;
    endfunction

    task automatic add_item(t_action act, t_port port, logic [7:0] b);
        t_timer_item it;
        it       = '0;
        it.act   = act;
        it.port  = port;
        it.wbyte = b;
        stim_q.push_back(it);
    endtask

    // Mostly ticks and complete channel programming with small counts, plus
    // control writes, status reads, truncated loads and raw noise.
    task automatic build_random();
        int          n_real;
        int          pick;
        int          ch;
        t_access     acc;
        logic [15:0] count;
        t_port       port;
        n_real = 0;
        while (n_real < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                add_item(ACT_TICK, t_port'($urandom_range(0, 7)), 8'($urandom));
                n_real++;
            end else if (pick < 70) begin
                ch    = $urandom_range(0, 1);
                acc   = t_access'($urandom_range(1, 3));
                port  = (ch == 0) ? PORT_CH0 : PORT_CH2;
                count = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(1, 24))
                                                    : 16'($urandom);
                add_item(ACT_WRITE, PORT_CMD, {(ch == 0) ? SEL_CH0 : SEL_CH2, acc,
                                               3'($urandom_range(0, 7)),
                                               1'($urandom_range(0, 1))});
                n_real++;
                case (acc)
                    ACC_LOW: add_item(ACT_WRITE, port, count[7:0]);
                    ACC_HIGH: add_item(ACT_WRITE, port,
                                       ($urandom_range(0, 3) != 0) ? 8'h01 : count[15:8]);
                    default: begin
                        add_item(ACT_WRITE, port, count[7:0]);
                        if ($urandom_range(0, 9) != 0) begin
                            if ($urandom_range(0, 7) == 0) add_item(ACT_TICK, PORT_CH0, 8'h00);
                            add_item(ACT_WRITE, port, count[15:8]);
                            n_real++;
                        end
                    end
                endcase
                n_real++;
            end else if (pick < 78) begin
                add_item(ACT_WRITE, PORT_CTL, {4'($urandom_range(0, 15)),
                                               2'($urandom_range(0, 3)),
                                               1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 3) != 0)});
                n_real++;
            end else if (pick < 88) begin
                add_item(ACT_READ, PORT_CTL, 8'($urandom));
                n_real++;
            end else begin
                add_item(t_action'($urandom_range(0, 3)), t_port'($urandom_range(0, 7)),
                         8'($urandom));
                n_real++;
            end
        end
    endtask

    task automatic check_result();
        t_timer_beat got;
        t_timer_beat want;
        got = '{result_if.read_byte, result_if.irq_pulse, result_if.out_two, result_if.speaker};
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Unexpected result beat: read_byte %02h irq %0b out_two %0b speaker %0b",
                         got.rd_data, got.irq, got.ch2_out, got.spk);
        end else begin
            want = expected_beats.pop_front();
            n_checked++;
            if (want.irq) n_irq++;
            if (got.rd_data !== want.rd_data || got.irq !== want.irq ||
                got.ch2_out !== want.ch2_out || got.spk !== want.spk) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Beat %0d: read_byte %02h/%02h irq %0b/%0b out_two %0b/%0b %s%0b/%0b",
                             n_checked, want.rd_data, got.rd_data, want.irq, got.irq,
                             want.ch2_out, got.ch2_out, "speaker ", want.spk, got.spk);
            end
        end
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) check_result();
    end

    // Sender: bursts of random length separated by random gaps.
    initial begin
        t_timer_beat beat;
        item_if.valid       = 1'b0;
        item_if.action      = ACT_TICK;
        item_if.port_select = PORT_CH0;
        item_if.write_byte  = 8'h00;
        forever begin
            @(posedge i_clk);
            if (item_if.valid && item_if.ready) begin
                beat = timer_step(cur_item.act, cur_item.port, cur_item.wbyte);
                expected_beats.push_back(cur_item.fixed ? cur_item.beat : beat);
                n_accepted++;
                if (cur_item.act == ACT_TICK) n_ticks++;
            end
            if (go && (!item_if.valid || item_if.ready)) begin
                if (gap_left == 0 && stim_q.size() != 0) begin
                    cur_item = stim_q.pop_front();
                    item_if.valid       <= 1'b1;
                    item_if.action      <= cur_item.act;
                    item_if.port_select <= cur_item.port;
                    item_if.write_byte  <= cur_item.wbyte;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    item_if.valid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end
            end
        end
    end

    // Receiver: phases of always ready, a rotating stall pattern, or random stalls.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(16, 96);
                rx_pat  = 8'($urandom);
            end else begin
                rx_left--;
            end
            rx_pat = {rx_pat[0], rx_pat[7:1]};
            result_if.ready <= (rx_mode == 0) || (rx_mode == 1 && rx_pat[0]) ||
                               (rx_mode == 2 && $urandom_range(0, 3) != 0);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d beats outstanding",
                 cycle_count, expected_beats.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_DIRECTED; i++) stim_q.push_back(DIRECTED[i]);
        build_random();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        go      <= 1'b1;
        do @(negedge i_clk);
        while (stim_q.size() != 0 || item_if.valid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            $display("%0d expected beats never arrived", expected_beats.size());
            mismatches += expected_beats.size();
        end
        $display("Ran %0d items (%0d directed, %0d timer ticks), checked %0d result beats",
                 n_accepted, NUM_DIRECTED, n_ticks, n_checked);
        $display("with %0d channel-0 interrupt pulses and %0d mismatches.", n_irq, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
